// ===== design/i2j_pkg.sv =====
package i2j_pkg;

  localparam logic [7:0] ESC_CHR   = 8'h1B;
  localparam logic [7:0] NL_CHR    = 8'h0A;
  localparam logic [7:0] CR_CHR    = 8'h0D;
  localparam logic [7:0] SS2_CHR   = 8'h8E;
  localparam logic [7:0] SS3_CHR   = 8'h8F;
  localparam logic [7:0] LPAREN    = 8'h28;
  localparam logic [7:0] DOLLAR    = 8'h24;
  localparam logic [7:0] DASH      = 8'h2D;
  localparam logic [7:0] CHR_J     = 8'h4A;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_I     = 8'h49;
  localparam logic [7:0] CHR_AT    = 8'h40;
  localparam logic [7:0] CHR_D     = 8'h44;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] SJ_SPLIT  = 8'h5F;
  localparam logic [7:0] SJ_LEAD_LO = 8'h70;
  localparam logic [7:0] SJ_LEAD_HI = 8'hB0;
  localparam logic [7:0] SJ_ODD_HI = 8'h20;
  localparam logic [7:0] SJ_ODD_LO = 8'h1F;
  localparam logic [7:0] SJ_EVEN   = 8'h7E;

  // Largest number of output bytes that one input byte can cause.
  localparam int unsigned MAX_OUT = 6;

  typedef enum logic [1:0] {
    MODE_ROMAN = 2'd0,
    MODE_KANA  = 2'd1,
    MODE_X0208 = 2'd2,
    MODE_X0212 = 2'd3
  } mode_e;

  // All output bytes caused by one input byte, oldest in entry zero.
  typedef struct packed {
    logic [2:0]               cnt;
    logic [MAX_OUT-1:0][7:0]  bytes;
  } job_t;

  // Outcome of decoding one unit (character or escape) at the window start.
  typedef struct packed {
    logic            brk;
    logic [2:0]      used;
    logic [1:0]      n_emit;
    logic [2:0][7:0] emit;
    mode_e           mode;
  } step_t;

  function automatic step_t parse_step(logic [3:0][7:0] w, logic [2:0] avail,
                                       mode_e mode, logic euc);
    step_t      r;
    logic [8:0] c_inc;
    logic [7:0] c;
    logic [7:0] c2;
    c         = w[0];
    c2        = w[1];
    c_inc     = {1'b0, c} + 9'd1;
    r.brk     = 1'b0;
    r.used    = 3'd1;
    r.n_emit  = 2'd0;
    r.emit    = '0;
    r.mode    = mode;
    priority if (c == ESC_CHR) begin
      if (avail < 3'd3) begin
        r.brk = 1'b1;
      end else if (w[1] == LPAREN) begin
        if (w[2] == CHR_J || w[2] == CHR_B) begin
          r.mode = MODE_ROMAN;
          r.used = 3'd3;
        end else if (w[2] == CHR_I) begin
          r.mode = MODE_KANA;
          r.used = 3'd3;
        end else begin
          r.emit[0] = w[0];
          r.emit[1] = w[1];
          r.n_emit  = 2'd2;
          r.used    = 3'd2;
        end
      end else if (w[1] == DOLLAR) begin
        if (w[2] == CHR_B || w[2] == CHR_AT) begin
          r.mode = MODE_X0208;
          r.used = 3'd3;
        end else if (w[2] == LPAREN && avail < 3'd4) begin
          r.brk = 1'b1;
        end else if (w[2] == LPAREN && w[3] == CHR_D) begin
          r.mode = euc ? MODE_X0212 : MODE_X0208;
          r.used = 3'd4;
        end else begin
          r.emit[0] = w[0];
          r.emit[1] = w[1];
          r.n_emit  = 2'd2;
          r.used    = 3'd2;
        end
      end else if (w[1] == DASH) begin
        if (w[2] == CHR_A) begin
          r.mode = MODE_ROMAN;
          r.used = 3'd3;
        end else begin
          r.emit[0] = w[0];
          r.emit[1] = w[1];
          r.n_emit  = 2'd2;
          r.used    = 3'd2;
        end
      end else begin
        r.emit[0] = c;
        r.n_emit  = 2'd1;
      end
    end else if (c == NL_CHR || c == CR_CHR) begin
      r.mode    = MODE_ROMAN;
      r.emit[0] = c;
      r.n_emit  = 2'd1;
    end else if (mode == MODE_X0208) begin
      if (avail < 3'd2) begin
        r.brk = 1'b1;
      end else begin
        r.used   = 3'd2;
        r.n_emit = 2'd2;
        if (euc) begin
          r.emit[0] = c | HIGH_BIT;
          r.emit[1] = c2 | HIGH_BIT;
        end else begin
          r.emit[0] = 8'(c_inc >> 1) + ((c < SJ_SPLIT) ? SJ_LEAD_LO : SJ_LEAD_HI);
          if (c[0]) begin
            r.emit[1] = c2 + ((c2 > SJ_SPLIT) ? SJ_ODD_HI : SJ_ODD_LO);
          end else begin
            r.emit[1] = c2 + SJ_EVEN;
          end
        end
      end
    end else if (mode == MODE_X0212) begin
      if (avail < 3'd2) begin
        r.brk = 1'b1;
      end else begin
        r.used    = 3'd2;
        r.n_emit  = 2'd3;
        r.emit[0] = SS3_CHR;
        r.emit[1] = c | HIGH_BIT;
        r.emit[2] = c2 | HIGH_BIT;
      end
    end else if (mode == MODE_KANA) begin
      if (euc) begin
        r.emit[0] = SS2_CHR;
        r.emit[1] = c | HIGH_BIT;
        r.n_emit  = 2'd2;
      end else begin
        r.emit[0] = c | HIGH_BIT;
        r.n_emit  = 2'd1;
      end
    end else begin
      r.emit[0] = c;
      r.n_emit  = 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== design/i2j_front.sv =====
module i2j_front
  import i2j_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  euc_i,
  input  logic  accept_i,
  input  logic  [7:0] in_byte_i,
  output logic  push_o,
  output job_t  job_o
);

  mode_e           mode_q, mode_d;
  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_cnt_q, held_cnt_d;

  logic [7:0][7:0] bx;
  logic [3:0][7:0] win;
  logic [2:0]      n_bytes;
  logic [2:0]      pos;
  logic [2:0]      left;
  logic [2:0]      ocnt;
  logic            done;
  step_t           st;
  mode_e           md;

  // Up to four bytes are in play: the held ones followed by the new one.
  // At most four decode units fit in them, so four unrolled steps finish.
  always_comb begin
    bx = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < held_cnt_q) begin
        bx[i] = held_q[i];
      end
    end
    bx[{1'b0, held_cnt_q}] = in_byte_i;
    n_bytes   = {1'b0, held_cnt_q} + 3'd1;
    pos       = '0;
    ocnt      = '0;
    done      = 1'b0;
    md        = mode_q;
    job_o     = '0;
    win       = '0;
    st        = '0;
    for (int s = 0; s < 4; s++) begin
      if (!done && pos < n_bytes) begin
        for (int k = 0; k < 4; k++) begin
          win[k] = bx[3'(pos + 3'(k))];
        end
        st = parse_step(win, n_bytes - pos, md, euc_i);
        if (st.brk) begin
          done = 1'b1;
        end else begin
          for (int e = 0; e < 3; e++) begin
            if (2'(e) < st.n_emit && ocnt < 3'(MAX_OUT)) begin
              job_o.bytes[ocnt] = st.emit[e];
              ocnt = ocnt + 3'd1;
            end
          end
          pos = pos + st.used;
          md  = st.mode;
        end
      end
    end
    job_o.cnt = ocnt;
    for (int k = 0; k < 3; k++) begin
      held_d[k] = bx[3'(pos + 3'(k))];
    end
    left       = n_bytes - pos;
    held_cnt_d = left[1:0];
    mode_d     = md;
  end

  assign push_o = accept_i && (ocnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ROMAN;
      held_cnt_q <= '0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

  // X0212 mode is only entered while EUC output is selected.
  a_x0212_needs_euc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !euc_i && mode_q != MODE_X0212 |=> mode_q != MODE_X0212)
    else $error("X0212 mode entered with Shift-JIS output");

endmodule

// ===== design/i2j_queue.sv =====
module i2j_queue
  import i2j_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_job_i,
  output logic full_o,
  input  logic rd_i,
  output job_t rd_job_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // The front only writes while there is room, so no job is ever dropped.
  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("job written into a full queue");

endmodule

// ===== design/i2j_back.sv =====
module i2j_back
  import i2j_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       q_job_i,
  output logic       q_rd_o,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic [2:0] idx_q;
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       can_load;
  logic       load;
  logic       is_last;

  assign can_load = !out_vld_q || pop;
  assign load     = can_load && !q_empty_i;
  assign is_last  = (idx_q == q_job_i.cnt - 3'd1);
  assign q_rd_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (can_load) begin
        out_vld_q <= !q_empty_i;
      end
      if (load) begin
        idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= q_job_i.bytes[idx_q];
      out_last_q <= is_last;
    end
  end

  assign empty         = !out_vld_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

  a_job_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> (q_job_i.cnt != 3'd0) && (q_job_i.cnt <= 3'(MAX_OUT)))
    else $error("queued job has an invalid byte count");

  a_index_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> idx_q < q_job_i.cnt)
    else $error("byte index beyond the current job");

  a_index_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty_i |-> idx_q == 3'd0)
    else $error("byte index left over with no job queued");

endmodule

// ===== design/iso2022jp_to_sjis_euc_transcoder.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------
// input     | in        | push / full          | in_byte_i (8 bits, JIS stream)
// result    | out       | pop / empty          | out_byte_o (8), last_of_run_o (1)
// config    | in        | cfg_we_i (no wait)   | cfg_wdata_i (target_euc, 1 bit)
//
// One input byte is taken per cycle while the job queue has room; the front
// decodes it with any held bytes in that same cycle and queues its job, if any.
// Result bytes leave at one per cycle while popped, so a k-byte item holds the
// output until its last byte leaves; the QueueDepth-entry queue absorbs bursts.
// Reset clears the mode to Roman, drops held bytes and empties the queue.
// A stalled output holds its byte; the front keeps accepting until full.
module iso2022jp_to_sjis_euc_transcoder
  import i2j_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  // Output encoding: zero selects Shift-JIS, one selects EUC-JP.
  logic target_euc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_euc_q <= 1'b0;
    end else if (cfg_we_i) begin
      target_euc_q <= cfg_wdata_i;
    end
  end

  logic accept;
  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;
  job_t wr_job;
  job_t rd_job;

  // An input transfer happens whenever the queue can take a job, whether or
  // not this particular byte ends up producing one.
  assign full   = q_full;
  assign accept = push && !q_full;

  // The front keeps the character mode and held bytes and turns each input
  // byte into a job of zero to six output bytes.
  i2j_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .euc_i     (target_euc_q),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .push_o    (q_wr),
    .job_o     (wr_job)
  );

  // Short queue of jobs that decouples decoding from byte serialization.
  i2j_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_job_i (wr_job),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_job_o (rd_job),
    .empty_o  (q_empty)
  );

  // The back walks through the head job one byte per cycle, as pop allows, into a
  // registered output stage and flags the final byte of each job.
  i2j_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_job_i       (rd_job),
    .q_rd_o        (q_rd),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
